FILE: rtl/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg: shared constants and tables of the ray scale selector
// Image size, scale limit, register indexes and the reciprocal table.
// ----------------------------------------------------------------------------
package rss_pkg;

	localparam int MaxScale  = 32;
	localparam int ImgWidth  = 64;
	localparam int ImgHeight = 64;
	localparam int RowW      = 6;
	localparam int ColW      = 6;
	localparam int AddrW     = RowW + ColW;
	localparam int PixW      = 16;

	localparam logic [1:0] REG_SCALE = 2'd0;
	localparam logic [1:0] REG_SQRT  = 2'd1;
	localparam logic [1:0] REG_MASK  = 2'd2;

	// Reciprocal table: round(2^16 / k^2.5) for the steps k = 1..31, Q1.16;
	// zero elsewhere.
	function automatic logic [16:0] recip(input logic [5:0] k);
		logic [16:0] r;
		case (k)
			6'd1: r = 17'd65536; 6'd2: r = 17'd11585; 6'd3: r = 17'd4204;
			6'd4: r = 17'd2048;  6'd5: r = 17'd1172;  6'd6: r = 17'd743;
			6'd7: r = 17'd506;   6'd8: r = 17'd362;   6'd9: r = 17'd270;
			6'd10: r = 17'd207;  6'd11: r = 17'd163;  6'd12: r = 17'd131;
			6'd13: r = 17'd108;  6'd14: r = 17'd89;   6'd15: r = 17'd75;
			6'd16: r = 17'd64;   6'd17: r = 17'd55;   6'd18: r = 17'd48;
			6'd19: r = 17'd42;   6'd20: r = 17'd37;   6'd21: r = 17'd32;
			6'd22: r = 17'd29;   6'd23: r = 17'd26;   6'd24: r = 17'd23;
			6'd25: r = 17'd21;   6'd26: r = 17'd19;   6'd27: r = 17'd17;
			6'd28: r = 17'd16;   6'd29: r = 17'd14;   6'd30: r = 17'd13;
			6'd31: r = 17'd12;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/ray_scale_selector.sv
// ----------------------------------------------------------------------------
// ray_scale_selector: characteristic scale search along four rays
// Walks rays out of a keypoint through the stored image and picks a scale.
// ----------------------------------------------------------------------------
// A load transaction leaves busy low.
// A query passes over skipped directions; each visited step of an enabled
// direction makes three pixel reads on the one read port of the image memory,
// an accumulate, a multiply and a compare, and the query ends by strobing
// result_valid with best_scale.
// The receiver cannot stall. Reset clears control and the registers; the image
// memory is not cleared.
module ray_scale_selector import rss_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   req_type,
	input  logic [RowW-1:0]        row,
	input  logic [ColW-1:0]        col,
	input  logic signed [PixW-1:0] pixel_value,
	output logic                   result_valid,
	output logic [4:0]             best_scale,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [15:0]            cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIR  = 3'd1; // pick next direction
	localparam logic [2:0] ST_RDK  = 3'd2; // read p(k), check offsets
	localparam logic [2:0] ST_RDN  = 3'd3;
	localparam logic [2:0] ST_RDM  = 3'd4;
	localparam logic [2:0] ST_ACC  = 3'd5; // p(m) arrives, accumulate
	localparam logic [2:0] ST_MUL  = 3'd6;
	localparam logic [2:0] ST_CMP  = 3'd7;

	logic [2:0]  state_q;
	logic [15:0] scale_q, sqrt_q;
	logic [3:0]  mask_q;
	logic [RowW-1:0] row_q;
	logic [ColW-1:0] col_q;
	logic [2:0]  dir_q;      // 4 means all directions done
	logic [5:0]  k_q;
	logic [5:0]  bound_q;
	logic [15:0] acc_q;
	logic signed [31:0] best_norm_q, norm_q;
	logic [5:0]  best_step_q;
	logic signed [PixW-1:0] pk_q, pn_q;
	logic [11:0] n_q, m_q;

	logic [AddrW-1:0] raddr;
	logic signed [PixW-1:0] rdata;
	logic ram_we;

	assign busy   = (state_q != ST_IDLE);
	assign ram_we = start && !busy && !req_type;

	rss_pixel_ram u_ram (
		.clk(clk), .we(ram_we), .waddr({row, col}), .wdata(pixel_value),
		.raddr(raddr), .rdata(rdata)
	);

	// Room to the edge for the direction in dir_q.
	logic [6:0] room;
	always_comb begin
		case (dir_q[1:0])
			2'd0: room = 7'(ImgWidth) - {1'b0, col_q};
			2'd1: room = {1'b0, col_q};
			2'd2: room = 7'(ImgHeight) - {1'b0, row_q};
			default: room = {1'b0, row_q};
		endcase
	end

	// Offsets of the far and middle samples for step k.
	logic [21:0] n_full, m_full;
	assign n_full = scale_q * k_q + 22'd2048;
	assign m_full = sqrt_q * k_q + 22'd2048;

	// An offset stays inside the image when it is below room going right or
	// down, and when it is at most room going left or up.
	logic n_ok, m_ok;
	assign n_ok = dir_q[0] ? ({2'b0, n_full[21:12]} <= {5'b0, room})
	                       : ({2'b0, n_full[21:12]} < {5'b0, room});
	assign m_ok = dir_q[0] ? ({2'b0, m_full[21:12]} <= {5'b0, room})
	                       : ({2'b0, m_full[21:12]} < {5'b0, room});

	function automatic logic [AddrW-1:0] addr_of(input logic [1:0] d,
		input logic [RowW-1:0] r, input logic [ColW-1:0] c, input logic [5:0] off);
		logic [AddrW-1:0] a;
		case (d)
			2'd0: a = {r, c + off};
			2'd1: a = {r, c - off};
			2'd2: a = {r + off, c};
			default: a = {r - off, c};
		endcase
		return a;
	endfunction

	always_comb begin
		case (state_q)
			ST_RDN:  raddr = addr_of(dir_q[1:0], row_q, col_q, n_q[5:0]);
			ST_RDM:  raddr = addr_of(dir_q[1:0], row_q, col_q, m_q[5:0]);
			default: raddr = addr_of(dir_q[1:0], row_q, col_q, k_q);
		endcase
	end

	logic [15:0] dm, dn;
	logic signed [16:0] dmf, dnf;
	assign dmf = 17'(rdata) - 17'(pk_q);
	assign dnf = 17'(pn_q) - 17'(pk_q);
	assign dm  = dmf[16] ? 16'(-dmf) : dmf[15:0];
	assign dn  = dnf[16] ? 16'(-dnf) : dnf[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scale_q <= 16'd4096;
			sqrt_q <= 16'd4096;
			mask_q <= 4'hF;
			result_valid <= 1'b0;
			best_scale <= '0;
			dir_q <= '0;
			k_q <= '0;
			acc_q <= '0;
			best_norm_q <= '0;
			best_step_q <= '0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_SCALE: scale_q <= cfg_data;
					REG_SQRT:  sqrt_q <= cfg_data;
					REG_MASK:  mask_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (start && req_type) begin
						row_q <= row;
						col_q <= col;
						dir_q <= '0;
						best_norm_q <= '0;
						best_step_q <= '0;
						state_q <= ST_DIR;
					end
				end
				ST_DIR: begin
					if (dir_q[2]) begin
						result_valid <= 1'b1;
						best_scale <= best_step_q[5] ? 5'd31 : best_step_q[4:0];
						state_q <= ST_IDLE;
					end else if (!mask_q[dir_q[1:0]]) begin
						dir_q <= dir_q + 3'd1;
					end else begin
						bound_q <= (room < 7'(MaxScale)) ? room[5:0] : 6'(MaxScale);
						acc_q <= '0;
						k_q <= 6'd1;
						state_q <= ST_RDK;
					end
				end
				ST_RDK: begin
					// k >= bound, or a far or middle sample off the image, ends the ray.
					if ({1'b0, k_q} >= {1'b0, bound_q} || !n_ok || !m_ok) begin
						dir_q <= dir_q + 3'd1;
						state_q <= ST_DIR;
					end else begin
						n_q <= {2'b0, n_full[21:12]};
						m_q <= {2'b0, m_full[21:12]};
						state_q <= ST_RDN;
					end
				end
				ST_RDN: begin
					pk_q <= rdata;
					state_q <= ST_RDM;
				end
				ST_RDM: begin
					pn_q <= rdata;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					acc_q <= acc_q + dm - dn;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					norm_q <= 32'($signed(acc_q) * $signed({1'b0, recip(k_q)}));
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (norm_q >= best_norm_q) begin
						best_norm_q <= norm_q;
						if (k_q > best_step_q) best_step_q <= k_q;
					end
					k_q <= k_q + 6'd1;
					state_q <= ST_RDK;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/rss_pixel_ram.sv
// ----------------------------------------------------------------------------
// rss_pixel_ram: image store
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module rss_pixel_ram import rss_pkg::*; (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AddrW-1:0]        waddr,
	input  logic signed [PixW-1:0]  wdata,
	input  logic [AddrW-1:0]        raddr,
	output logic signed [PixW-1:0]  rdata
);

	logic signed [PixW-1:0] mem_q [ImgWidth*ImgHeight];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: verif/ray_scale_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_scale_checker: scoreboard of the ray scale selector
// Mirrors the image and registers from the watched transactions, predicts
// best_scale for each query and compares it with every result strobe.
// ----------------------------------------------------------------------------
module ray_scale_checker import rss_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  logic                   req_type,
	input  logic [RowW-1:0]        row,
	input  logic [ColW-1:0]        col,
	input  logic signed [PixW-1:0] pixel_value,
	input  logic                   result_valid,
	input  logic [4:0]             best_scale,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [15:0]            cfg_data,
	output int                     fail_count,
	output int                     pending,
	output int                     query_count
);

	logic signed [15:0] image_mirror [ImgHeight*ImgWidth];
	logic [15:0]        far_factor;
	logic [15:0]        mid_factor;
	logic [3:0]         dir_enable;
	logic [4:0]         scale_queue [$];

	// Reciprocal entry round(2^16/k^2.5): largest r with (2r-1)^2 * k^5 <= 2^34.
	function automatic longint recip_of(input int k);
		longint k5, lo, hi, mid, t;
		k5 = longint'(k) * k * k * k * k;
		lo = 0;
		hi = 65536 / (k * k) + 1;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			t = 2 * mid - 1;
			if (t * t * k5 <= (64'd1 << 34))
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo;
	endfunction

	// Fetches a sample along direction d; returns 0 when it leaves the image.
	function automatic bit ray_sample(input int d, input int r, input int c,
			input int off, output int v);
		int rr, cc;
		rr = r;
		cc = c;
		case (d)
			0: begin if (off >= ImgWidth - c) return 0; cc = c + off; end
			1: begin if (off > c) return 0; cc = c - off; end
			2: begin if (off >= ImgHeight - r) return 0; rr = r + off; end
			default: begin if (off > r) return 0; rr = r - off; end
		endcase
		v = image_mirror[rr*ImgWidth + cc];
		return 1;
	endfunction

	function automatic int abs_gap(input int a, input int b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic logic [4:0] predict_scale(input int r, input int c);
		int best_step, room, bound, pk, pn, pm, n, m;
		longint best_val, norm;
		logic [15:0] acc;
		best_step = 0;
		best_val = 0;
		for (int d = 0; d < 4; d++) begin
			if (!dir_enable[d]) continue;
			case (d)
				0: room = ImgWidth - c;
				1: room = c;
				2: room = ImgHeight - r;
				default: room = r;
			endcase
			bound = (room < MaxScale) ? room : MaxScale;
			acc = '0;
			for (int k = 1; k < bound; k++) begin
				n = (int'(far_factor) * k + 2048) >>> 12;
				m = (int'(mid_factor) * k + 2048) >>> 12;
				if (!ray_sample(d, r, c, k, pk) || !ray_sample(d, r, c, n, pn) ||
						!ray_sample(d, r, c, m, pm))
					break;
				acc = acc + 16'(abs_gap(pm, pk)) - 16'(abs_gap(pn, pk));
				norm = longint'($signed(acc)) * recip_of(k);
				norm = longint'(int'(norm));
				if (norm >= best_val) begin
					best_val = norm;
					if (k > best_step) best_step = k;
				end
			end
		end
		return (best_step > 31) ? 5'd31 : 5'(best_step);
	endfunction

	assign pending = scale_queue.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			far_factor  <= 16'd4096;
			mid_factor  <= 16'd4096;
			dir_enable  <= 4'hF;
			fail_count  <= 0;
			query_count <= 0;
			scale_queue.delete();
		end else begin
			if (result_valid) begin
				if (scale_queue.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0d",
						$time, best_scale);
					fail_count <= fail_count + 1;
				end else begin
					if (scale_queue[0] !== best_scale) begin
						$display("%0t: best_scale expected %0d actual %0d",
							$time, scale_queue[0], best_scale);
						fail_count <= fail_count + 1;
					end
					void'(scale_queue.pop_front());
				end
			end
			if (start && !busy) begin
				if (!req_type) begin
					image_mirror[row*ImgWidth + col] = pixel_value;
				end else begin
					scale_queue.push_back(predict_scale(row, col));
					query_count <= query_count + 1;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_SCALE: far_factor <= cfg_data;
					REG_SQRT:  mid_factor <= cfg_data;
					REG_MASK:  dir_enable <= cfg_data[3:0];
					default: ;
				endcase
			end
		end
	end

endmodule

FILE: verif/ray_scale_selector_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_scale_selector_test: top of the ray scale selector testbench
// Fills the rows and columns that queries walk, then runs directed and random
// load and query transactions under several register settings while the
// checker scores every result.
// ----------------------------------------------------------------------------
module ray_scale_selector_test;
	import rss_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic                   req_type = 1'b0;
	logic [RowW-1:0]        row = '0;
	logic [ColW-1:0]        col = '0;
	logic signed [PixW-1:0] pixel_value = '0;
	logic                   result_valid;
	logic [4:0]             best_scale;
	logic                   cfg_we = 1'b0;
	logic [1:0]             cfg_index = '0;
	logic [15:0]            cfg_data = '0;
	int                     fail_count;
	int                     pending;
	int                     query_count;
	int                     load_count;
	bit                     quiet_stretch;

	// Queries sit only on these rows and columns, so a ray never reads a pixel
	// outside them and only these lines need loading first.
	int key_rows [7] = '{0, 1, 5, 10, 20, 32, 63};
	int key_cols [9] = '{0, 5, 12, 32, 40, 50, 60, 62, 63};

	// The clock period is 2 ns.
	always #1 clk = ~clk;

	ray_scale_selector dut (.*);

	ray_scale_checker scoreboard (.*);

	function automatic bit on_key_line(input int r, input int c);
		bit hit;
		hit = 1'b0;
		foreach (key_rows[i]) if (key_rows[i] == r) hit = 1'b1;
		foreach (key_cols[i]) if (key_cols[i] == c) hit = 1'b1;
		return hit;
	endfunction

	// Hands one transaction to the block. The sender idles at random except in
	// the quiet stretch. Start stays high between back-to-back transactions so
	// it never sees two assignments in one step.
	task automatic send_item(input logic kind, input int r, input int c,
			input logic [15:0] value);
		while (!quiet_stretch && $urandom_range(99) < 34) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		req_type    <= kind;
		row         <= RowW'(r);
		col         <= ColW'(c);
		pixel_value <= value;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (kind == 1'b0) load_count++;
	endtask

	task automatic send_query(input int r, input int c);
		send_item(1'b1, r, c, 16'h0);
	endtask

	task automatic send_load(input int r, input int c, input logic [15:0] value);
		send_item(1'b0, r, c, value);
	endtask

	// Registers change only while idle: drain every expected result, then wait
	// out a little more so the block has settled.
	task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_factors(input logic [15:0] far_q, input logic [15:0] mid_q,
			input logic [3:0] mask);
		write_reg(REG_SCALE, far_q);
		write_reg(REG_SQRT, mid_q);
		write_reg(REG_MASK, {12'h0, mask});
	endtask

	// Random phase: mostly queries on the loaded lines, with loads mixed in
	// anywhere so the image keeps changing under the queries.
	task automatic random_phase(input int count);
		for (int i = 0; i < count; i++) begin
			quiet_stretch = (i >= count / 3) && (i < count / 3 + 60);
			if ($urandom_range(99) < 40)
				send_load($urandom_range(63), $urandom_range(63), 16'($urandom));
			else
				send_query(key_rows[$urandom_range(6)], key_cols[$urandom_range(8)]);
		end
		quiet_stretch = 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every pixel a query can reach is written before any query reads it.
		quiet_stretch = 1'b1;
		for (int r = 0; r < ImgHeight; r++)
			for (int c = 0; c < ImgWidth; c++)
				if (on_key_line(r, c))
					send_load(r, c, 16'($urandom));
		quiet_stretch = 1'b0;

		// Directed part: corners, edges, center and extreme pixel values.
		send_load(0, 0, 16'h8000);
		send_load(63, 63, 16'h7FFF);
		send_load(0, 63, 16'hFFFF);
		send_load(32, 33, 16'h0000);
		send_query(0, 0);
		send_query(63, 63);
		send_query(0, 63);
		send_query(63, 0);
		send_query(32, 32);
		send_query(1, 62);
		// Far sample offsets that leave the image at once or early.
		set_factors(16'hFFFF, 16'hFFFF, 4'hF);
		send_query(32, 32);
		send_query(10, 50);
		set_factors(16'h0000, 16'h0000, 4'h0);
		send_query(32, 32);
		set_factors(16'h0000, 16'h0000, 4'h1);
		send_query(5, 5);
		set_factors(16'h2000, 16'h16A1, 4'h2);
		send_query(20, 60);
		set_factors(16'h4000, 16'h2000, 4'h4);
		send_query(0, 40);
		set_factors(16'h1800, 16'h139B, 4'h8);
		send_query(63, 12);

		// Random part under several settings, including the reset values.
		set_factors(16'd4096, 16'd4096, 4'hF);
		random_phase(150);
		set_factors(16'h2000, 16'h16A1, 4'hF);
		random_phase(150);
		set_factors(16'h1800, 16'h139B, 4'h5);
		random_phase(150);
		set_factors(16'($urandom_range(4096, 16384)),
			16'($urandom_range(4096, 8192)), 4'($urandom));
		random_phase(150);
		set_factors(16'($urandom), 16'($urandom), 4'hA);
		random_phase(130);
		set_factors(16'hFFFF, 16'h0000, 4'hF);
		random_phase(120);

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Covered %0d pixel loads and %0d scale queries under many settings.",
			load_count, query_count);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// The timeout allows several times the slowest correct run.
	initial begin
		#20000000;
		$display("Timed out waiting for results.");
		$display("Mismatches found");
		$finish;
	end

endmodule
